FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the delimiter balance checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DLB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: lbl");

// Check that a condition implies a consequence in the same cycle.
`define DLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Check that a condition implies a consequence in the next cycle.
`define DLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

FILE: hdl/dlb_pkg.sv
// ----------------------------------------------------------------------------
// dlb_pkg
// Types, codes and character constants of the delimiter balance checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlb_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;

  // Kind reported on top of the stack; the stack cells store the low two bits.
  typedef enum logic [2:0] {
    KIND_PAREN = 3'd0,
    KIND_BRACE = 3'd1,
    KIND_QUOTE = 3'd2,
    KIND_BLOCK = 3'd3,
    KIND_EMPTY = 3'd4
  } top_kind_e;

  typedef logic [1:0] kind_t;

  // Per-beat result status.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_FAILED    = 2'd3
  } status_e;

  // Stack shift command shared by all cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_NUL       = 8'h00;

endpackage

FILE: hdl/dlb_if.sv
// ----------------------------------------------------------------------------
// dlb_in_if / dlb_out_if
// Valid/ready channels carrying text bytes in and scan results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface dlb_out_if #(
  parameter int unsigned DEPTH_W = 7
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [DEPTH_W-1:0] depth;
  logic [2:0]         top_kind;
  logic               in_line_comment;

  modport source (output valid, output status, output depth, output top_kind,
                  output in_line_comment, input ready);
  modport sink   (input valid, input status, input depth, input top_kind,
                  input in_line_comment, output ready);
endinterface

FILE: hdl/dlb_cell.sv
// ----------------------------------------------------------------------------
// dlb_cell
// One entry of the shifting stack: takes its upper neighbor on push and its
// lower neighbor on pop, holds otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlb_cell
  import dlb_pkg::*;
(
  input  logic      clk_i,
  input  stack_op_t op_i,
  input  kind_t     prev_kind_i,
  input  kind_t     next_kind_i,
  output kind_t     kind_o
);

  kind_t kind_q;

  // Shift toward the bottom on push, toward the top on pop.
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      kind_q <= prev_kind_i;
    end else if (op_i.pop) begin
      kind_q <= next_kind_i;
    end
  end

  assign kind_o = kind_q;

endmodule

FILE: hdl/dlb_skid.sv
// ----------------------------------------------------------------------------
// dlb_skid
// Two-entry output buffer: an output register plus a skid register that
// catches a beat taken during a stall; input is not ready while it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlb_skid #(
  parameter int unsigned WIDTH = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  logic [WIDTH-1:0] main_q;
  logic [WIDTH-1:0] skid_q;
  logic             in_fire;
  logic             out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && out_ready_i;

  // Control: refill from skid first, else take the new beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        main_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= in_data_i;
      end else begin
        main_q <= in_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = main_q;

endmodule

FILE: hdl/delimiter_balance_checker.sv
// ----------------------------------------------------------------------------
// delimiter_balance_checker
// Byte-serial nesting checker for C source text.
// ----------------------------------------------------------------------------
// Accepts one text byte per clock and returns one registered result beat per
// byte through a two-entry output buffer; the input stays ready as long as
// that buffer has room, so the sustained rate is one byte per cycle while the
// result side does not stall. The rate is set by the combinational scan
// step: each byte needs only the top stack entry, the depth counter and a
// few flags. The open constructs live in a row of STACK_DEPTH shifting cells
// whose first cell is the top of the stack; push and pop shift the whole
// row. No clearing pass runs after reset; entries above the depth counter
// are never reported. An unmatched closer or a push onto a full stack fails
// the block, and every later beat reports the failed status until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimiter_balance_checker
  import dlb_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dlb_in_if.sink        text_i,
  dlb_out_if.source     result_o
);

  localparam int unsigned RES_W = 2 + DEPTH_W + 3 + 1;

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [7:0]         prev_q, prev_d;
  logic               lc_q, lc_d;
  logic               esc_q, esc_d;
  logic               failed_q, failed_d;

  kind_t              kinds [STACK_DEPTH];
  stack_op_t          op;
  kind_t              push_kind;
  logic               want_push;
  logic               in_fire;
  logic               buf_ready;
  logic [7:0]         c;
  logic [2:0]         top_now;
  logic [2:0]         top_after;
  status_e            status;
  logic               stack_full;
  logic [RES_W-1:0]   res_data;
  logic [RES_W-1:0]   out_data;

  assign c          = text_i.text_byte;
  assign in_fire    = text_i.valid && buf_ready;
  assign text_i.ready = buf_ready;
  assign stack_full = (depth_q == DEPTH_W'(STACK_DEPTH));
  assign top_now    = (depth_q == '0) ? KIND_EMPTY : {1'b0, kinds[0]};

  // Scan step: decide the stack command and next flags for this byte.
  always_comb begin
    depth_d   = depth_q;
    prev_d    = prev_q;
    lc_d      = lc_q;
    esc_d     = esc_q;
    failed_d  = failed_q;
    want_push = 1'b0;
    push_kind = kind_t'(KIND_PAREN);
    op        = '0;
    status    = ST_OK;
    if (in_fire) begin
      if (failed_q) begin
        status = ST_FAILED;
      end else if (esc_q) begin
        esc_d  = 1'b0;
        prev_d = CH_NUL;
      end else if (c == CH_BACKSLASH) begin
        esc_d  = 1'b1;
        prev_d = c;
      end else if (lc_q) begin
        if (c == CH_NEWLINE) begin
          lc_d = 1'b0;
        end
        prev_d = c;
      end else if (top_now == KIND_BLOCK) begin
        if (prev_q == CH_STAR && c == CH_SLASH) begin
          op.pop = 1'b1;
          prev_d = CH_NUL;
        end else begin
          prev_d = c;
        end
      end else if (top_now == KIND_QUOTE) begin
        if (c == CH_QUOTE) begin
          op.pop = 1'b1;
        end
        prev_d = c;
      end else begin
        prev_d = c;
        if (c == CH_SLASH && prev_q == CH_SLASH) begin
          lc_d   = 1'b1;
          prev_d = CH_NUL;
        end else if (c == CH_STAR && prev_q == CH_SLASH) begin
          prev_d    = CH_NUL;
          want_push = 1'b1;
          push_kind = kind_t'(KIND_BLOCK);
        end else if (c == CH_QUOTE) begin
          want_push = 1'b1;
          push_kind = kind_t'(KIND_QUOTE);
        end else if (c == CH_LPAREN) begin
          want_push = 1'b1;
          push_kind = kind_t'(KIND_PAREN);
        end else if (c == CH_LBRACE) begin
          want_push = 1'b1;
          push_kind = kind_t'(KIND_BRACE);
        end else if (c == CH_RPAREN) begin
          if (top_now != KIND_PAREN) begin
            status = ST_UNMATCHED;
          end else begin
            op.pop = 1'b1;
          end
        end else if (c == CH_RBRACE) begin
          if (top_now != KIND_BRACE) begin
            status = ST_UNMATCHED;
          end else begin
            op.pop = 1'b1;
          end
        end
      end

      // Push only when there is room; otherwise flag overflow.
      if (want_push) begin
        if (stack_full) begin
          status = ST_OVERFLOW;
        end else begin
          op.push = 1'b1;
        end
      end

      if (op.push) begin
        depth_d = depth_q + DEPTH_W'(1);
      end else if (op.pop) begin
        depth_d = depth_q - DEPTH_W'(1);
      end

      if (status != ST_OK) begin
        failed_d = 1'b1;
      end
    end
  end

  // Top of stack after this byte.
  always_comb begin
    if (op.push) begin
      top_after = {1'b0, push_kind};
    end else if (op.pop) begin
      top_after = (depth_d == '0) ? KIND_EMPTY : {1'b0, kinds[1]};
    end else begin
      top_after = top_now;
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      prev_q   <= CH_NUL;
      lc_q     <= 1'b0;
      esc_q    <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      prev_q   <= prev_d;
      lc_q     <= lc_d;
      esc_q    <= esc_d;
      failed_q <= failed_d;
    end
  end

  // Row of stack cells; cell zero is the top.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t prev_kind;
    kind_t next_kind;
    if (i == 0) begin : g_first
      assign prev_kind = push_kind;
    end else begin : g_mid
      assign prev_kind = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_kind = kinds[i];
    end else begin : g_inner
      assign next_kind = kinds[i+1];
    end
    dlb_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .prev_kind_i (prev_kind),
      .next_kind_i (next_kind),
      .kind_o      (kinds[i])
    );
  end

  assign res_data = {status, depth_d, top_after, lc_d};

  // Output buffer decouples the result side.
  dlb_skid #(
    .WIDTH (RES_W)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (text_i.valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res_data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (out_data)
  );

  assign result_o.status          = out_data[RES_W-1 -: 2];
  assign result_o.depth           = out_data[4 +: DEPTH_W];
  assign result_o.top_kind        = out_data[3:1];
  assign result_o.in_line_comment = out_data[0];

endmodule

FILE: hdl/dlb_checker.sv
// ----------------------------------------------------------------------------
// dlb_checker
// Port-level assertions for the delimiter balance checker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dlb_checker
  import dlb_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH,
  parameter int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         status_i,
  input logic [DEPTH_W-1:0] depth_i,
  input logic [2:0]         top_kind_i
);

  logic out_fire;
  logic fail_seen_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Remember that a failing beat has been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_seen_q <= 1'b0;
    end else if (out_fire && (status_i == ST_UNMATCHED || status_i == ST_OVERFLOW)) begin
      fail_seen_q <= 1'b1;
    end
  end

  `DLB_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `DLB_ASSERT_IMP(a_empty_top, clk_i, rst_ni, out_valid_i, (depth_i == '0) == (top_kind_i == KIND_EMPTY))
  `DLB_ASSERT_IMP(a_depth_max, clk_i, rst_ni, out_valid_i, depth_i <= DEPTH_W'(STACK_DEPTH))
  `DLB_ASSERT_IMP(a_sticky_fail, clk_i, rst_ni, out_fire && fail_seen_q, status_i == ST_FAILED)

endmodule

bind delimiter_balance_checker dlb_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .DEPTH_W     (DEPTH_W)
) u_dlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .status_i    (result_o.status),
  .depth_i     (result_o.depth),
  .top_kind_i  (result_o.top_kind)
);
